@@ design/swept_box_collision_resolve_macros.svh @@
// assertion macros shared by the swept box collision resolve rtl
// included by the modules that carry checks; no other dependencies
`ifndef SWEPT_BOX_COLLISION_RESOLVE_MACROS_SVH
`define SWEPT_BOX_COLLISION_RESOLVE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is high
`define SBCR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbcr assertion failed");
// next-cycle implication, disabled while reset is high
`define SBCR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbcr assertion failed");
`else
`define SBCR_ASSERT_NOW(name, clk, rst, ante, cons)
`define SBCR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ design/sbcr_pkg.sv @@
// shared types, constants and vector helpers for the swept box collision resolve
// used by sbcr_axis and swept_box_collision_resolve; no dependencies
package sbcr_pkg;

   localparam int COORD_BITS  = 21;
   localparam int VEC_BITS    = 63;
   localparam int MODE_BITS   = 2;
   localparam int MARGIN_BITS = 4;
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;
   localparam int REG_IDX_BITS = 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   sum_type;
   typedef logic signed [COORD_BITS+2:0] wide_type;
   typedef logic [VEC_BITS-1:0]          vec_type;
   typedef logic [MODE_BITS-1:0]         mode_type;
   typedef logic [MARGIN_BITS-1:0]       margin_type;
   typedef logic [REG_IDX_BITS-1:0]      reg_idx_type;

   // resolve modes
   localparam mode_type MODE_ALL   = 2'd0;
   localparam mode_type MODE_FIRST = 2'd1;

   // register indexes
   localparam reg_idx_type REG_MODE   = 1'b0;
   localparam reg_idx_type REG_MARGIN = 1'b1;

   localparam margin_type MARGIN_RESET = 4'd1;

   localparam wide_type COORD_MAX = wide_type'((64'sd1 <<< (COORD_BITS-1)) - 64'sd1);
   localparam wide_type COORD_MIN = -COORD_MAX - wide_type'(1);

   // per-axis operands of one box pair
   typedef struct packed {
      coord_type p;
      coord_type q;
      coord_type b;
      coord_type bp;
      coord_type ml;
      coord_type mh;
      coord_type bl;
      coord_type bh;
   } axis_in_type;

   typedef struct packed {
      logic      hit_max;
      logic      hit_min;
      coord_type coord;
   } axis_res_type;

   function automatic coord_type vec_unpack(vec_type w, int a);
      return w[a*COORD_BITS +: COORD_BITS];
   endfunction

   function automatic vec_type vec_pack(coord_type x, coord_type y, coord_type z);
      vec_type r;
      r = '0;
      r[COORD_BITS-1:0]              = x;
      r[2*COORD_BITS-1:COORD_BITS]   = y;
      r[3*COORD_BITS-1:2*COORD_BITS] = z;
      return r;
   endfunction

   function automatic coord_type sat_coord(wide_type v);
      if (v > COORD_MAX) begin
         return coord_type'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         return coord_type'(COORD_MIN);
      end
      return coord_type'(v);
   endfunction

endpackage

@@ design/sbcr_axis.sv @@
// one axis of the swept box test: side overlap, face crossing and push-out
// depends on sbcr_pkg
module sbcr_axis
   import sbcr_pkg::*;
(
   input  axis_in_type  own,
   input  axis_in_type  side_a,
   input  axis_in_type  side_b,
   input  logic         active,
   input  logic         detect,
   input  margin_type   margin,
   output axis_res_type res
);

   function automatic sum_type add2(coord_type a, coord_type b);
      return sum_type'(a) + sum_type'(b);
   endfunction

   function automatic logic overlap(axis_in_type s);
      return (add2(s.b, s.bh) >= add2(s.p, s.ml)) && (add2(s.b, s.bl) <= add2(s.p, s.mh));
   endfunction

   logic     tested;
   logic     cross_max;
   logic     cross_min;
   wide_type marg_w;
   wide_type target_max;
   wide_type target_min;

   always_comb begin
      tested    = active && overlap(side_a) && overlap(side_b);
      cross_max = tested && (add2(own.bp, own.bh) <= add2(own.q, own.ml))
                         && (add2(own.b, own.bh) >= add2(own.p, own.ml));
      // max face wins when both faces were crossed
      cross_min = tested && !cross_max
                         && (add2(own.bp, own.bl) >= add2(own.q, own.mh))
                         && (add2(own.b, own.bl) <= add2(own.p, own.mh));
      marg_w     = wide_type'({1'b0, margin});
      target_max = wide_type'(own.b) + wide_type'(own.bh) - wide_type'(own.ml) + marg_w;
      target_min = wide_type'(own.b) + wide_type'(own.bl) - wide_type'(own.mh) - marg_w;

      res.hit_max = cross_max;
      res.hit_min = cross_min;
      if (detect) begin
         res.coord = own.p;
      end else if (cross_max) begin
         res.coord = sat_coord(target_max);
      end else if (cross_min) begin
         res.coord = sat_coord(target_min);
      end else begin
         res.coord = own.p;
      end
   end

endmodule

@@ design/swept_box_collision_resolve.sv @@
// swept box collision resolve top level: input register, x/z/y axis chain,
// result register and csr block; depends on sbcr_pkg, sbcr_axis and the macros
//
// usage:
//   req channel carries one mover/block box pair per item (eight packed vectors
//   of three signed coordinates); rsp channel returns the pushed mover position,
//   a hit flag and six face flags. both channels use valid/stall; an item moves
//   at a clock edge with valid high and stall low.
//   an accepted item goes from the input register to the result register, which
//   drives rsp. throughput: one item per cycle while rsp_stall is low, set by the
//   single x-z-y adder/compare chain between the input and result registers.
//   when rsp_stall is high the result register holds; the input register still
//   takes one more item, after which req_stall rises until the result leaves.
//   csr: apb-style, register 0 resolve mode at 0x0, register 1 push margin at
//   0x4; write only while no item is in flight. pready is always high.
//   reset (synchronous) empties both registers and sets mode 0, margin 1.
`include "swept_box_collision_resolve_macros.svh"
module swept_box_collision_resolve
   import sbcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vec_type              req_mover_pos,
   input  vec_type              req_mover_prev,
   input  vec_type              req_block_pos,
   input  vec_type              req_block_prev,
   input  vec_type              req_mover_lo,
   input  vec_type              req_mover_hi,
   input  vec_type              req_block_lo,
   input  vec_type              req_block_hi,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vec_type              rsp_new_pos,
   output logic                 rsp_any_hit,
   output logic                 rsp_hit_right,
   output logic                 rsp_hit_left,
   output logic                 rsp_hit_far,
   output logic                 rsp_hit_near,
   output logic                 rsp_hit_top,
   output logic                 rsp_hit_bottom,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   mode_type   mode_ff;
   margin_type margin_ff;

   logic    in_valid_ff,  in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    in_open, out_open;
   vec_type mp_ff, mq_ff, bp_ff, bq_ff, ml_ff, mh_ff, bl_ff, bh_ff;

   vec_type    new_pos_ff, new_pos_in;
   logic [5:0] hits_ff, hits_in;
   logic       any_ff, any_in;

   reg_idx_type  reg_idx;
   logic         detect;
   logic         stop_first;
   axis_in_type  ax_in [3];
   axis_in_type  x_own, x_sa, x_sb;
   axis_in_type  z_own, z_sa, z_sb;
   axis_in_type  y_own, y_sa, y_sb;
   axis_res_type x_res, z_res, y_res;
   logic         z_active, y_active;
   vec_type      mover_clean;

   // csr port
   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ALL;
         margin_ff <= MARGIN_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_MODE:   mode_ff   <= pwdata[MODE_BITS-1:0];
            REG_MARGIN: margin_ff <= pwdata[MARGIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_MODE:   prdata[MODE_BITS-1:0]   = mode_ff;
         REG_MARGIN: prdata[MARGIN_BITS-1:0] = margin_ff;
         default:    prdata = '0;
      endcase
   end

   // flow control
   assign out_open     = !out_valid_ff || !rsp_stall;
   assign in_open      = !in_valid_ff || out_open;
   assign req_stall    = !in_open;
   assign in_valid_in  = in_open ? req_valid : in_valid_ff;
   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_open && req_valid) begin
         mp_ff <= req_mover_pos;
         mq_ff <= req_mover_prev;
         bp_ff <= req_block_pos;
         bq_ff <= req_block_prev;
         ml_ff <= req_mover_lo;
         mh_ff <= req_mover_hi;
         bl_ff <= req_block_lo;
         bh_ff <= req_block_hi;
      end
   end

   // per-axis operands from the input register
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ax_in[a].p  = vec_unpack(mp_ff, a);
         ax_in[a].q  = vec_unpack(mq_ff, a);
         ax_in[a].b  = vec_unpack(bp_ff, a);
         ax_in[a].bp = vec_unpack(bq_ff, a);
         ax_in[a].ml = vec_unpack(ml_ff, a);
         ax_in[a].mh = vec_unpack(mh_ff, a);
         ax_in[a].bl = vec_unpack(bl_ff, a);
         ax_in[a].bh = vec_unpack(bh_ff, a);
      end
   end

   assign detect     = mode_ff[1];
   assign stop_first = (mode_ff == MODE_FIRST);

   // axis order x, z, y; later axes see the pushed coordinates
   always_comb begin
      x_own = ax_in[0];
      x_sa  = ax_in[1];
      x_sb  = ax_in[2];

      z_own   = ax_in[2];
      z_sa    = ax_in[0];
      z_sa.p  = x_res.coord;
      z_sb    = ax_in[1];

      y_own   = ax_in[1];
      y_sa    = ax_in[2];
      y_sa.p  = z_res.coord;
      y_sb    = ax_in[0];
      y_sb.p  = x_res.coord;

      z_active = !((x_res.hit_max || x_res.hit_min) && (detect || stop_first));
      y_active = z_active && !((z_res.hit_max || z_res.hit_min) && (detect || stop_first));
   end

   sbcr_axis u_axis_x (
      .own    (x_own),
      .side_a (x_sa),
      .side_b (x_sb),
      .active (1'b1),
      .detect (detect),
      .margin (margin_ff),
      .res    (x_res)
   );

   sbcr_axis u_axis_z (
      .own    (z_own),
      .side_a (z_sa),
      .side_b (z_sb),
      .active (z_active),
      .detect (detect),
      .margin (margin_ff),
      .res    (z_res)
   );

   sbcr_axis u_axis_y (
      .own    (y_own),
      .side_a (y_sa),
      .side_b (y_sb),
      .active (y_active),
      .detect (detect),
      .margin (margin_ff),
      .res    (y_res)
   );

   always_comb begin
      new_pos_in = vec_pack(x_res.coord, y_res.coord, z_res.coord);
      // right, left, far, near, top, bottom
      hits_in    = {y_res.hit_min, y_res.hit_max, z_res.hit_min, z_res.hit_max,
                    x_res.hit_min, x_res.hit_max};
      any_in     = |hits_in;
      mover_clean = vec_pack(ax_in[0].p, ax_in[1].p, ax_in[2].p);
   end

   always_ff @(posedge clock) begin
      if (out_open && in_valid_ff) begin
         new_pos_ff <= new_pos_in;
         hits_ff    <= hits_in;
         any_ff     <= any_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_new_pos    = new_pos_ff;
   assign rsp_any_hit    = any_ff;
   assign rsp_hit_right  = hits_ff[0];
   assign rsp_hit_left   = hits_ff[1];
   assign rsp_hit_far    = hits_ff[2];
   assign rsp_hit_near   = hits_ff[3];
   assign rsp_hit_top    = hits_ff[4];
   assign rsp_hit_bottom = hits_ff[5];

   // stop-at-first and detect-only flag at most one face
   `SBCR_ASSERT_NOW(a_single_face, clock, reset, in_valid_ff && mode_ff != MODE_ALL, $countones(hits_in) <= 1)
   // no item reports both faces of one axis
   `SBCR_ASSERT_NOW(a_one_face_per_axis, clock, reset, in_valid_ff, !(hits_in[0] && hits_in[1]) && !(hits_in[2] && hits_in[3]) && !(hits_in[4] && hits_in[5]))
   // a miss leaves the mover where it was
   `SBCR_ASSERT_NOW(a_miss_keeps_pos, clock, reset, in_valid_ff && !any_in, new_pos_in == mover_clean)
   // detect-only never moves the mover
   `SBCR_ASSERT_NOW(a_detect_no_push, clock, reset, in_valid_ff && detect, new_pos_in == mover_clean)
   // an item in the input register reaches the result register when it is open
   `SBCR_ASSERT_NEXT(a_item_advances, clock, reset, in_valid_ff && out_open, out_valid_ff)

endmodule

@@ test/sbcr_tb_pkg.sv @@
`timescale 1ns / 100ps
// box pair and result types, the push-out predictor and the queue of awaited results
// for the swept box collision resolve testbench; depends on sbcr_pkg only
package sbcr_tb_pkg;
   import sbcr_pkg::*;

   localparam mode_type MODE_DETECT     = 2'd2;
   localparam mode_type MODE_DETECT_ALT = 2'd3;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   localparam int FACE_RIGHT  = 0;
   localparam int FACE_LEFT   = 1;
   localparam int FACE_FAR    = 2;
   localparam int FACE_NEAR   = 3;
   localparam int FACE_TOP    = 4;
   localparam int FACE_BOTTOM = 5;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      vec_type mover_pos;
      vec_type mover_prev;
      vec_type block_pos;
      vec_type block_prev;
      vec_type mover_lo;
      vec_type mover_hi;
      vec_type block_lo;
      vec_type block_hi;
   } box_pair_type;

   typedef struct packed {
      vec_type new_pos;
      logic    any_hit;
      logic    hit_right;
      logic    hit_left;
      logic    hit_far;
      logic    hit_near;
      logic    hit_top;
      logic    hit_bottom;
   } pair_result_type;

   function automatic wide_type coord_at(vec_type w, int a);
      coord_type c;
      c = w[a*COORD_BITS +: COORD_BITS];
      return wide_type'(c);
   endfunction

   function automatic wide_type clamp_coord(wide_type v);
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end else if (v < COORD_MIN) begin
         return COORD_MIN;
      end
      return v;
   endfunction

   // face flagged when the mover hits the block's max face on this axis
   function automatic int max_face(int ax);
      if (ax == AXIS_X) begin
         return FACE_RIGHT;
      end else if (ax == AXIS_Z) begin
         return FACE_FAR;
      end
      return FACE_TOP;
   endfunction

   class push_out_checker;
      mode_type        mode;
      int              margin;
      pair_result_type awaited[$];
      int              errors;
      int              checked;
      int              hits;

      function new();
         mode    = MODE_ALL;
         margin  = int'(MARGIN_RESET);
         errors  = 0;
         checked = 0;
         hits    = 0;
      endfunction

      function pair_result_type resolve_pair(box_pair_type it);
         wide_type        p[3], q[3], b[3], bp[3], ml[3], mh[3], bl[3], bh[3];
         int              order[3];
         logic [5:0]      face_hit;
         logic            detect, stop_first, hit, ov1, ov2;
         int              ax, o1, o2, face;
         wide_type        target;
         pair_result_type r;
         order      = '{AXIS_X, AXIS_Z, AXIS_Y};
         face_hit   = '0;
         hit        = 1'b0;
         target     = '0;
         detect     = (mode == MODE_DETECT) || (mode == MODE_DETECT_ALT);
         stop_first = (mode == MODE_FIRST);
         for (int a = 0; a < 3; a++) begin
            p[a]  = coord_at(it.mover_pos, a);
            q[a]  = coord_at(it.mover_prev, a);
            b[a]  = coord_at(it.block_pos, a);
            bp[a] = coord_at(it.block_prev, a);
            ml[a] = coord_at(it.mover_lo, a);
            mh[a] = coord_at(it.mover_hi, a);
            bl[a] = coord_at(it.block_lo, a);
            bh[a] = coord_at(it.block_hi, a);
         end
         for (int k = 0; k < 3; k++) begin
            ax   = order[k];
            o1   = (ax + 1) % 3;
            o2   = (ax + 2) % 3;
            face = -1;
            // overlap on the other two axes uses the position as pushed so far
            ov1 = (b[o1] + bh[o1] >= p[o1] + ml[o1]) && (b[o1] + bl[o1] <= p[o1] + mh[o1]);
            ov2 = (b[o2] + bh[o2] >= p[o2] + ml[o2]) && (b[o2] + bl[o2] <= p[o2] + mh[o2]);
            if (ov1 && ov2) begin
               if ((bp[ax] + bh[ax] <= q[ax] + ml[ax]) && (b[ax] + bh[ax] >= p[ax] + ml[ax]))
               begin
                  face   = max_face(ax);
                  target = b[ax] + bh[ax] - ml[ax] + wide_type'(margin);
               end else if ((bp[ax] + bl[ax] >= q[ax] + mh[ax]) &&
                            (b[ax] + bl[ax] <= p[ax] + mh[ax])) begin
                  face   = max_face(ax) + 1;
                  target = b[ax] + bl[ax] - mh[ax] - wide_type'(margin);
               end
            end
            if (face >= 0) begin
               face_hit[face] = 1'b1;
               hit            = 1'b1;
               if (detect) break;
               p[ax] = clamp_coord(target);
               if (stop_first) break;
            end
         end
         r.new_pos    = {coord_type'(p[AXIS_Z]), coord_type'(p[AXIS_Y]),
                         coord_type'(p[AXIS_X])};
         r.any_hit    = hit;
         r.hit_right  = face_hit[FACE_RIGHT];
         r.hit_left   = face_hit[FACE_LEFT];
         r.hit_far    = face_hit[FACE_FAR];
         r.hit_near   = face_hit[FACE_NEAR];
         r.hit_top    = face_hit[FACE_TOP];
         r.hit_bottom = face_hit[FACE_BOTTOM];
         return r;
      endfunction

      function void note_pair(box_pair_type it);
         awaited.push_back(resolve_pair(it));
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
      endtask

      task compare_flag(string name, logic got, logic want);
         if (got !== want) begin
            report($sformatf("result %0d %s got %b want %b", checked, name, got, want));
         end
      endtask

      task check_result(pair_result_type got);
         pair_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result with no box pair waiting, new_pos %h", got.new_pos));
         end else begin
            want = awaited.pop_front();
            if (got.new_pos !== want.new_pos) begin
               report($sformatf("result %0d new_pos got %h want %h",
                                checked, got.new_pos, want.new_pos));
            end
            compare_flag("any_hit", got.any_hit, want.any_hit);
            compare_flag("hit_right", got.hit_right, want.hit_right);
            compare_flag("hit_left", got.hit_left, want.hit_left);
            compare_flag("hit_far", got.hit_far, want.hit_far);
            compare_flag("hit_near", got.hit_near, want.hit_near);
            compare_flag("hit_top", got.hit_top, want.hit_top);
            compare_flag("hit_bottom", got.hit_bottom, want.hit_bottom);
            if (want.any_hit) hits++;
            checked++;
         end
      endtask
   endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// top of the swept box collision resolve testbench: clock, reset, csr and item drivers,
// result monitor and run sequence; depends on sbcr_pkg, sbcr_tb_pkg and the rtl
module tb_top;
   import sbcr_pkg::*;
   import sbcr_tb_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int SETTINGS_USED   = 10;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   box_pair_type         drive_pair = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   vec_type              rsp_new_pos;
   logic                 rsp_any_hit, rsp_hit_right, rsp_hit_left, rsp_hit_far;
   logic                 rsp_hit_near, rsp_hit_top, rsp_hit_bottom;
   logic                 psel       = 1'b0;
   logic                 penable    = 1'b0;
   logic                 pwrite     = 1'b0;
   logic [ADDR_BITS-1:0] paddr      = '0;
   logic [DATA_BITS-1:0] pwdata     = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;
   logic                 calm       = 1'b0;
   int                   stall_left = 0;
   int                   cycle_count = 0;
   pair_result_type      rsp_seen;
   push_out_checker      chk = new();

   assign rsp_seen = {rsp_new_pos, rsp_any_hit, rsp_hit_right, rsp_hit_left, rsp_hit_far,
                      rsp_hit_near, rsp_hit_top, rsp_hit_bottom};

   always #1 clock = ~clock;

   swept_box_collision_resolve u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mover_pos  (drive_pair.mover_pos),
      .req_mover_prev (drive_pair.mover_prev),
      .req_block_pos  (drive_pair.block_pos),
      .req_block_prev (drive_pair.block_prev),
      .req_mover_lo   (drive_pair.mover_lo),
      .req_mover_hi   (drive_pair.mover_hi),
      .req_block_lo   (drive_pair.block_lo),
      .req_block_hi   (drive_pair.block_hi),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_new_pos    (rsp_new_pos),
      .rsp_any_hit    (rsp_any_hit),
      .rsp_hit_right  (rsp_hit_right),
      .rsp_hit_left   (rsp_hit_left),
      .rsp_hit_far    (rsp_hit_far),
      .rsp_hit_near   (rsp_hit_near),
      .rsp_hit_top    (rsp_hit_top),
      .rsp_hit_bottom (rsp_hit_bottom),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // mostly short, now and then long
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return $urandom_range(2);
      end else if (pick < 95) begin
         return $urandom_range(8, 3);
      end
      return $urandom_range(60, 20);
   endfunction

   function automatic int spread(int r);
      return int'($urandom_range(2 * r)) - r;
   endfunction

   function automatic vec_type vec_of(int x, int y, int z);
      return {coord_type'(z), coord_type'(y), coord_type'(x)};
   endfunction

   // block at the origin on y and z, unit-ish extents; x of the block is free
   function automatic box_pair_type make_pair(input int px, py, pz, qx, qy, qz,
                                              input int bx, bpx, blx, bhx);
      box_pair_type it;
      it.mover_pos  = vec_of(px, py, pz);
      it.mover_prev = vec_of(qx, qy, qz);
      it.block_pos  = vec_of(bx, 0, 0);
      it.block_prev = vec_of(bpx, 0, 0);
      it.mover_lo   = vec_of(-4, -4, -4);
      it.mover_hi   = vec_of(4, 4, 4);
      it.block_lo   = vec_of(blx, -4, -4);
      it.block_hi   = vec_of(bhx, 4, 4);
      return it;
   endfunction

   function automatic box_pair_type uniform_pair(int mv, int bv);
      box_pair_type it;
      it.mover_pos  = vec_of(mv, mv, mv);
      it.mover_prev = vec_of(mv, mv, mv);
      it.mover_lo   = vec_of(mv, mv, mv);
      it.mover_hi   = vec_of(mv, mv, mv);
      it.block_pos  = vec_of(bv, bv, bv);
      it.block_prev = vec_of(bv, bv, bv);
      it.block_lo   = vec_of(bv, bv, bv);
      it.block_hi   = vec_of(bv, bv, bv);
      return it;
   endfunction

   function automatic box_pair_type random_pair();
      logic [$bits(box_pair_type)-1:0] raw;
      int           p[3], q[3], b[3], bp[3], ml[3], mh[3], bl[3], bh[3];
      int           pick, ext, c;
      box_pair_type it;
      pick = $urandom_range(99);
      if (pick < 8) begin
         raw = '0;
         for (int i = 0; i < 16; i++) raw = {raw[$bits(box_pair_type)-33:0], $urandom};
         return box_pair_type'(raw);
      end
      for (int a = 0; a < 3; a++) begin
         if (pick < 16) begin
            // near the ends of the range with big extents, so pushes saturate
            c   = $urandom_range(1) ? int'(COORD_MAX) - int'($urandom_range(60))
                                    : int'(COORD_MIN) + int'($urandom_range(60));
            ext = 3000;
         end else begin
            c   = spread(1 << 19);
            ext = 40;
         end
         ml[a] = -int'($urandom_range(ext));
         mh[a] = $urandom_range(ext);
         bl[a] = -int'($urandom_range(ext));
         bh[a] = $urandom_range(ext);
         b[a]  = c + spread(32);
         bp[a] = b[a] + spread(ext / 4);
         p[a]  = b[a] + spread(($urandom_range(3) == 0) ? 4 * ext : ext);
         q[a]  = p[a] + spread(4 * ext);
      end
      it.mover_pos  = vec_of(p[0], p[1], p[2]);
      it.mover_prev = vec_of(q[0], q[1], q[2]);
      it.block_pos  = vec_of(b[0], b[1], b[2]);
      it.block_prev = vec_of(bp[0], bp[1], bp[2]);
      it.mover_lo   = vec_of(ml[0], ml[1], ml[2]);
      it.mover_hi   = vec_of(mh[0], mh[1], mh[2]);
      it.block_lo   = vec_of(bl[0], bl[1], bl[2]);
      it.block_hi   = vec_of(bh[0], bh[1], bh[2]);
      return it;
   endfunction

   // called at a rising edge; returns at the edge where the item is taken
   task automatic send_pair(box_pair_type it);
      int gap;
      gap = calm ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      drive_pair <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(reg_idx_type idx, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(reg_idx_type idx, int want, int width);
      logic [DATA_BITS-1:0] mask;
      mask    = (DATA_BITS'(1) << width) - 1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== DATA_BITS'(want)) begin
         chk.report($sformatf("register %0d reads %h want %h", idx, prdata, want));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (chk.awaited.size() != 0);
   endtask

   task automatic random_pairs(int count);
      for (int n = 0; n < count; n++) begin
         calm <= (n % 50) < 10;
         send_pair(random_pair());
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;
   endtask

   task automatic run_phase(mode_type mode, int margin);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write(REG_MODE, int'(mode));
      chk.mode = mode;
      csr_write(REG_MARGIN, margin);
      chk.margin = margin;
      csr_check(REG_MODE, int'(mode), MODE_BITS);
      csr_check(REG_MARGIN, margin, MARGIN_BITS);
      random_pairs(ITEMS_PER_PHASE);
   endtask

   // result side stalls in stretches; no new stretch starts while calm
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall  <= !calm && !reset && ($urandom_range(99) < 35);
         stall_left = gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) chk.note_pair(drive_pair);
         if (rsp_valid && !rsp_stall) chk.check_result(rsp_seen);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("swept_box_collision_resolve verification failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(REG_MODE, int'(MODE_ALL), MODE_BITS);
      csr_check(REG_MARGIN, int'(MARGIN_RESET), MARGIN_BITS);

      // reset settings: all equal (both faces qualify, max wins), then range ends
      send_pair(box_pair_type'('0));
      send_pair(box_pair_type'('1));
      send_pair(uniform_pair(int'(COORD_MAX), int'(COORD_MIN)));
      send_pair(uniform_pair(int'(COORD_MIN), int'(COORD_MAX)));
      // resting inside, then apart on y
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, -4, 4));
      send_pair(make_pair(0, 1000, 0, 0, 1000, 0, 0, 0, -4, 4));
      // one crossing per face
      send_pair(make_pair(6, 0, 0, 20, 0, 0, 0, 0, -4, 4));
      send_pair(make_pair(-6, 0, 0, -20, 0, 0, 0, 0, -4, 4));
      send_pair(make_pair(0, 0, 6, 0, 0, 20, 0, 0, -4, 4));
      send_pair(make_pair(0, 0, -6, 0, 0, -20, 0, 0, -4, 4));
      send_pair(make_pair(0, 6, 0, 0, 20, 0, 0, 0, -4, 4));
      send_pair(make_pair(0, -6, 0, 0, -20, 0, 0, 0, -4, 4));
      // x push takes the mover off the block before y is looked at
      send_pair(make_pair(6, 6, 0, 20, 20, 0, 0, 0, -4, 4));
      send_pair(make_pair(6, 50, 0, 20, 50, 0, 0, 0, -4, 4));
      // pushes past either end of the coordinate range
      send_pair(make_pair(1000, 0, 0, 2000, 0, 0, int'(COORD_MAX) - 10, 0, -4, 1000));
      send_pair(make_pair(-1000, 0, 0, -2000, 0, 0, int'(COORD_MIN) + 10, 0, -1000, 4));
      random_pairs(ITEMS_PER_PHASE);

      run_phase(MODE_ALL, 0);
      run_phase(MODE_FIRST, 15);
      run_phase(MODE_DETECT, 7);
      run_phase(MODE_DETECT_ALT, 1);
      run_phase(MODE_FIRST, 0);
      run_phase(MODE_ALL, 15);
      run_phase(MODE_DETECT, 0);
      run_phase(MODE_ALL, $urandom_range(15));
      run_phase(MODE_FIRST, $urandom_range(15));

      wait_drained();
      repeat (10) @(posedge clock);
      $display("%0d box pairs checked under %0d register settings, %0d of them with a face hit",
               chk.checked, SETTINGS_USED, chk.hits);
      if (chk.errors == 0) begin
         $display("swept_box_collision_resolve verification clean");
      end else begin
         $display("swept_box_collision_resolve verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/sbcr_pkg.sv
design/sbcr_axis.sv
design/swept_box_collision_resolve.sv
test/sbcr_tb_pkg.sv
test/tb_top.sv
